// ----- hdl/fifo_task_queue_with_remove_by_id_assert.svh -----
// Assertion macros for the task queue.
// Used by fifo_task_queue_with_remove_by_id.sv; needs no other file.
`ifndef FIFO_TASK_QUEUE_WITH_REMOVE_BY_ID_ASSERT_SVH
`define FIFO_TASK_QUEUE_WITH_REMOVE_BY_ID_ASSERT_SVH
`ifndef SYNTH
`define FTQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FTQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define FTQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define FTQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/ftq_pkg.sv -----
// Shared types and constants of the task queue.
// No dependencies.
package ftq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 8;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    latch;
		logic    ins_wr;
		logic    mark;
		logic    step;
		logic    shift;
		logic    set_st;
		status_t st;
		logic    load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       zero;
		logic       hit;
		logic       last;
		logic       out_free;
	} stat_t;

endpackage

// ----- hdl/fifo_task_queue_with_remove_by_id.sv -----
// Top level of the ordered task queue with removal by id.
// Depends on ftq_pkg, ftq_ctrl, ftq_dp and the assertion header.
//
// channel  signals             carries
// in       in_valid/in_stall   op, task_id
// out      out_valid/out_stall status, head_id, head_valid, is_empty, entry_count
//
// Insert, query and a remove on an empty queue pass through idle, decode and done; any
// other remove also scans the entries from the front until the match or, on a miss, the
// last entry (one entry per cycle).
// Reset clears the count and the result valid flag; entries and result fields hold garbage until written.
// A new item is taken while a finished result waits; the next result waits for it.
module fifo_task_queue_with_remove_by_id #(
	parameter int QUEUE_DEPTH = ftq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = ftq_pkg::ID_BITS_DEF,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [ID_BITS-1:0] task_id,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [ID_BITS-1:0] head_id,
	output logic               head_valid,
	output logic               is_empty,
	output logic [CNT_W-1:0]   entry_count
);
	import ftq_pkg::*;

	`include "fifo_task_queue_with_remove_by_id_assert.svh"

	cmd_t  cmd;
	stat_t stat;

	ftq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ftq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.task_id     (task_id),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.head_id     (head_id),
		.head_valid  (head_valid),
		.is_empty    (is_empty),
		.entry_count (entry_count)
	);

	`FTQ_ASSERT_IMPL(a_cnt_bound, clk, arst_n, out_valid, entry_count <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
	`FTQ_ASSERT_IMPL(a_empty_cnt, clk, arst_n, out_valid, is_empty == (entry_count == '0), "empty flag disagrees with count")
	`FTQ_ASSERT_IMPL(a_full_cnt, clk, arst_n, out_valid && status == ST_FULL, entry_count == CNT_W'(QUEUE_DEPTH), "full status below depth")
	`FTQ_ASSERT_IMPL(a_no_both, clk, arst_n, cmd.ins_wr, !cmd.shift && !stat.full, "insert on full queue or with shift")

endmodule

// ----- hdl/ftq_ctrl.sv -----
// Control state machine of the task queue.
// Depends on ftq_pkg; drives the command struct into ftq_dp.
module ftq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ftq_pkg::stat_t stat,
	output ftq_pkg::cmd_t  cmd
);
	import ftq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (stat.op == OP_REMOVE && !stat.zero) state_d = S_SCAN;
				else state_d = S_DONE;
			end
			S_SCAN: begin
				if (stat.hit || stat.last) state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.st   = ST_OK;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				cmd.latch = in_valid;
			end
			S_DECODE: begin
				cmd.set_st = 1'b1;
				case (stat.op)
					OP_INSERT: begin
						if (stat.full) cmd.st = ST_FULL;
						else cmd.ins_wr = 1'b1;
					end
					OP_REMOVE: begin
						if (stat.zero) cmd.st = ST_NOT_FOUND;
						else cmd.mark = 1'b1;
					end
					default: cmd.st = ST_OK;
				endcase
			end
			S_SCAN: begin
				if (stat.hit) begin
					cmd.shift  = 1'b1;
					cmd.set_st = 1'b1;
				end else if (stat.last) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_NOT_FOUND;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_DONE: begin
				cmd.load = stat.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ----- hdl/ftq_dp.sv -----
// Datapath of the task queue: entry registers, count, match scan, result register.
// Depends on ftq_pkg; steered by ftq_ctrl through the command struct.
module ftq_dp #(
	parameter int QUEUE_DEPTH = ftq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = ftq_pkg::ID_BITS_DEF,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
	localparam int PTR_W      = $clog2(QUEUE_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          op,
	input  logic [ID_BITS-1:0]  task_id,
	input  ftq_pkg::cmd_t       cmd,
	output ftq_pkg::stat_t      stat,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [ID_BITS-1:0]  head_id,
	output logic                head_valid,
	output logic                is_empty,
	output logic [CNT_W-1:0]    entry_count
);
	import ftq_pkg::*;

	logic [ID_BITS-1:0]     ent_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] match_q;
	logic [PTR_W-1:0]       ptr_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [1:0]             op_q;
	logic [ID_BITS-1:0]     id_q;
	status_t                status_q;
	status_t                out_st_q;
	logic                   out_valid_q;
	logic [ID_BITS-1:0]     head_id_q;
	logic                   head_valid_q;
	logic [CNT_W-1:0]       out_cnt_q;
	logic                   out_free;

	assign out_free = !out_valid_q || !out_stall;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_ent
		always_ff @(posedge clk) begin
			if (cmd.ins_wr && cnt_q == CNT_W'(i)) begin
				ent_q[i] <= id_q;
			end else if (cmd.shift && PTR_W'(i) >= ptr_q) begin
				if (i < QUEUE_DEPTH - 1) ent_q[i] <= ent_q[(i + 1) % QUEUE_DEPTH];
			end
			if (cmd.mark) match_q[i] <= (ent_q[i] == id_q) && (CNT_W'(i) < cnt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= op;
			id_q <= task_id;
		end
		if (cmd.mark) ptr_q <= '0;
		else if (cmd.step) ptr_q <= ptr_q + PTR_W'(1);
		if (cmd.set_st) status_q <= cmd.st;
		if (cmd.load) begin
			out_st_q     <= status_q;
			head_id_q    <= (cnt_q == '0) ? '0 : ent_q[0];
			head_valid_q <= (cnt_q != '0);
			out_cnt_q    <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_wr) cnt_q <= cnt_q + CNT_W'(1);
			else if (cmd.shift) cnt_q <= cnt_q - CNT_W'(1);
			if (cmd.load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.op       = op_q;
		stat.full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
		stat.zero     = (cnt_q == '0);
		stat.hit      = match_q[ptr_q];
		stat.last     = (CNT_W'(ptr_q) + CNT_W'(1) == cnt_q);
		stat.out_free = out_free;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_st_q;
	assign head_id     = head_id_q;
	assign head_valid  = head_valid_q;
	assign is_empty    = !head_valid_q;
	assign entry_count = out_cnt_q;

endmodule

// ----- verif/tb_fifo_task_queue_with_remove_by_id.sv -----
// Testbench for the ordered task queue with removal by id: a directed table, then
// random insert/remove/query traffic checked against a behavioral queue model.
// Depends on ftq_pkg and fifo_task_queue_with_remove_by_id.
`timescale 1ns / 1ps

module tb_fifo_task_queue_with_remove_by_id;
	import ftq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int IDW   = ID_BITS_DEF;
	localparam int CW    = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam int RAND_ITEMS  = 2000;
	localparam int QUIET_ITEMS = 200;
	localparam int HOLD_AT     = 700;
	localparam int LONG_HOLD   = 250;
	localparam int DRAIN       = 40;
	localparam int STALL_LIMIT = 3000;
	localparam int PRINT_CAP   = 50;

	typedef struct packed {
		status_t        st;
		logic [IDW-1:0] head;
		logic           hv;
		logic           emp;
		logic [CW-1:0]  cnt;
	} qres_t;

	typedef struct {
		logic [1:0]     code;
		logic [IDW-1:0] id;
		bit             typed;
		qres_t          want;
	} plan_row_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	logic [1:0]     op = OP_QUERY;
	logic [IDW-1:0] task_id = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	logic [1:0]     status;
	logic [IDW-1:0] head_id;
	logic           head_valid;
	logic           is_empty;
	logic [CW-1:0]  entry_count;

	logic [IDW-1:0] ready_ids[$];
	qres_t          pending[$];
	plan_row_t      plan[$];
	int             errors = 0;
	int             sent = 0;
	int             busy_level = 1;
	int             idle_cycles = 0;
	bit             quiet = 1'b0;
	bit             held = 1'b0;

	fifo_task_queue_with_remove_by_id u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.task_id    (task_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.head_id    (head_id),
		.head_valid (head_valid),
		.is_empty   (is_empty),
		.entry_count(entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic mismatch(string msg);
		if (errors < PRINT_CAP)
			$display("[%0t] ERROR %s", $realtime, msg);
		errors++;
	endtask

	// queue update for one transfer; returns the state seen after it
	function automatic qres_t apply_op(logic [1:0] code, logic [IDW-1:0] id);
		qres_t   res;
		status_t st;
		int      hit;
		st  = ST_OK;
		hit = -1;
		case (code)
			OP_INSERT: begin
				if (ready_ids.size() >= DEPTH)
					st = ST_FULL;
				else
					ready_ids.push_back(id);
			end
			OP_REMOVE: begin
				for (int i = 0; i < ready_ids.size(); i++) begin
					if (ready_ids[i] == id) begin
						hit = i;
						break;
					end
				end
				if (hit < 0)
					st = ST_NOT_FOUND;
				else
					ready_ids.delete(hit);
			end
			default: ;
		endcase
		res.st   = st;
		res.hv   = ready_ids.size() != 0;
		res.emp  = ready_ids.size() == 0;
		res.head = res.hv ? ready_ids[0] : '0;
		res.cnt  = CW'(ready_ids.size());
		return res;
	endfunction

	function automatic void add_row(logic [1:0] code, logic [IDW-1:0] id, bit typed = 1'b0,
			qres_t want = '0);
		plan_row_t row;
		row.code  = code;
		row.id    = id;
		row.typed = typed;
		row.want  = want;
		plan.push_back(row);
	endfunction

	task automatic send(logic [1:0] code, logic [IDW-1:0] id, bit typed, qres_t want);
		qres_t pred;
		in_valid <= 1'b1;
		op       <= code;
		task_id  <= id;
		do @(posedge clk); while (in_stall);
		pred = apply_op(code, id);
		pending.push_back(typed ? want : pred);
		sent++;
		if (!quiet && busy_level != 0 && $urandom_range(0, busy_level == 1 ? 7 : 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	initial begin : stim
		int             r;
		int             mode;
		int             pool_hi;
		logic [1:0]     code;
		logic [IDW-1:0] id;

		add_row(OP_QUERY,  8'hAA, 1'b1, qres_t'{ST_OK, 8'h00, 1'b0, 1'b1, 5'd0});
		add_row(OP_REMOVE, 8'h00, 1'b1, qres_t'{ST_NOT_FOUND, 8'h00, 1'b0, 1'b1, 5'd0});
		add_row(OP_SPARE,  8'hFF, 1'b1, qres_t'{ST_OK, 8'h00, 1'b0, 1'b1, 5'd0});
		add_row(OP_INSERT, 8'h00, 1'b1, qres_t'{ST_OK, 8'h00, 1'b1, 1'b0, 5'd1});
		add_row(OP_INSERT, 8'hFF, 1'b1, qres_t'{ST_OK, 8'h00, 1'b1, 1'b0, 5'd2});
		add_row(OP_REMOVE, 8'hFF, 1'b1, qres_t'{ST_OK, 8'h00, 1'b1, 1'b0, 5'd1});
		add_row(OP_REMOVE, 8'h00, 1'b1, qres_t'{ST_OK, 8'h00, 1'b0, 1'b1, 5'd0});
		// fill to the brim, with repeated ids
		add_row(OP_INSERT, 8'h01);
		add_row(OP_INSERT, 8'h80);
		add_row(OP_INSERT, 8'h7F);
		add_row(OP_INSERT, 8'hFE);
		add_row(OP_INSERT, 8'h01);
		add_row(OP_INSERT, 8'h3C);
		add_row(OP_INSERT, 8'hC3);
		add_row(OP_INSERT, 8'h0F);
		add_row(OP_INSERT, 8'hF0);
		add_row(OP_INSERT, 8'h5A);
		add_row(OP_INSERT, 8'hA5);
		add_row(OP_INSERT, 8'h81);
		add_row(OP_INSERT, 8'h7E);
		add_row(OP_INSERT, 8'h02);
		add_row(OP_INSERT, 8'h40);
		add_row(OP_INSERT, 8'h01);
		add_row(OP_INSERT, 8'h77, 1'b1, qres_t'{ST_FULL, 8'h01, 1'b1, 1'b0, 5'd16});
		add_row(OP_REMOVE, 8'h55, 1'b1, qres_t'{ST_NOT_FOUND, 8'h01, 1'b1, 1'b0, 5'd16});

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send(plan[i].code, plan[i].id, plan[i].typed, plan[i].want);

		mode    = 0;
		pool_hi = 0;
		for (int k = 0; k < RAND_ITEMS; k++) begin
			quiet = k >= RAND_ITEMS - QUIET_ITEMS;
			if (k % 50 == 0) begin
				mode       = $urandom_range(0, 3);
				busy_level = $urandom_range(0, 2);
				pool_hi    = $urandom_range(0, (1 << (IDW - 3)) - 1);
			end
			if (quiet)
				busy_level = 0;
			r = $urandom_range(0, 99);
			case (mode)
				0: r = (r < 70) ? 0 : (r < 90) ? 1 : 2;
				1: r = (r < 25) ? 0 : (r < 90) ? 1 : 2;
				2: r = (r < 45) ? 0 : (r < 90) ? 1 : 2;
				default: r = (r < 30) ? 0 : (r < 55) ? 1 : 2;
			endcase
			if ($urandom_range(0, 2) == 0)
				id = IDW'($urandom_range(0, (1 << IDW) - 1));
			else
				id = IDW'((pool_hi << 3) | $urandom_range(0, 7));
			if (r == 0) begin
				code = OP_INSERT;
			end else if (r == 1) begin
				code = OP_REMOVE;
				if (ready_ids.size() != 0 && $urandom_range(0, 3) != 0)
					id = ready_ids[$urandom_range(0, ready_ids.size() - 1)];
			end else begin
				code = ($urandom_range(0, 4) == 0) ? OP_SPARE : OP_QUERY;
			end
			send(code, id, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side back-pressure, including one long hold-off
	initial begin : sink
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && sent >= HOLD_AT) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!quiet && busy_level != 0 &&
					$urandom_range(0, busy_level == 1 ? 7 : 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		qres_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				mismatch("result transfer with nothing pending");
			end else begin
				w = pending.pop_front();
				if (status !== w.st)
					mismatch($sformatf("status got %0h expected %0h", status, w.st));
				if (head_id !== w.head)
					mismatch($sformatf("head_id got %0h expected %0h", head_id, w.head));
				if (head_valid !== w.hv)
					mismatch($sformatf("head_valid got %0b expected %0b", head_valid, w.hv));
				if (is_empty !== w.emp)
					mismatch($sformatf("is_empty got %0b expected %0b", is_empty, w.emp));
				if (entry_count !== w.cnt)
					mismatch($sformatf("entry_count got %0d expected %0d", entry_count, w.cnt));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule
